// ----- src/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, command codes and the task table entry layout.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int TIME_W        = 16;
    localparam int PRI_W         = 8;
    localparam int ID_W          = 4;
    localparam int MAX_TASKS_DEF = 16;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [PRI_W-1:0]  priority_val;
        logic              done;
    } t_entry;

endpackage

// ----- src/priority_preemptive_scheduler.sv -----
// ----------------------------------------------------------------------------
// priority_preemptive_scheduler
// Preemptive priority scheduler advanced one time unit per tick item.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   command  | start / busy       | i_cmd, i_arrival_time, i_burst_time,
//            |                    | i_priority_req
//   result   | o_valid (1 cycle)  | o_busy_res, o_task_id, o_new_segment,
//            |                    | o_finished, o_finish_time, o_turnaround,
//            |                    | o_waiting
//
// A load item writes one table entry, or is ignored once the table is full;
// loads run back to back. A tick item holds busy while it scans: one table
// entry is read per cycle through the single memory read port, the last entry
// is then compared, and any picked entry is written back and the result
// registered. A new item is accepted only once busy is low again.
// The result strobe comes in the first cycle with busy low; it cannot be stalled.
// Reset is synchronous, active low; the table itself is not cleared.
// ----------------------------------------------------------------------------
module priority_preemptive_scheduler #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       i_cmd,
    input  logic [pps_pkg::TIME_W-1:0] i_arrival_time,
    input  logic [pps_pkg::TIME_W-1:0] i_burst_time,
    input  logic [pps_pkg::PRI_W-1:0]  i_priority_req,
    output logic                       busy,
    output logic                       o_valid,
    output logic                       o_busy_res,
    output logic [pps_pkg::ID_W-1:0]   o_task_id,
    output logic                       o_new_segment,
    output logic                       o_finished,
    output logic [pps_pkg::TIME_W-1:0] o_finish_time,
    output logic [pps_pkg::TIME_W-1:0] o_turnaround,
    output logic [pps_pkg::TIME_W-1:0] o_waiting
);
    import pps_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    t_entry           mem_rdata;

    pps_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .i_arrival_time (i_arrival_time),
        .i_burst_time   (i_burst_time),
        .i_priority_req (i_priority_req),
        .busy           (busy),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_valid        (o_valid),
        .o_busy_res     (o_busy_res),
        .o_task_id      (o_task_id),
        .o_new_segment  (o_new_segment),
        .o_finished     (o_finished),
        .o_finish_time  (o_finish_time),
        .o_turnaround   (o_turnaround),
        .o_waiting      (o_waiting)
    );

    pps_task_mem #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

// ----- src/pps_task_mem.sv -----
// ----------------------------------------------------------------------------
// pps_task_mem
// Task table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_task_mem #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [IDX_W-1:0]   i_waddr,
    input  pps_pkg::t_entry    i_wdata,
    input  logic               i_re,
    input  logic [IDX_W-1:0]   i_raddr,
    output pps_pkg::t_entry    o_rdata
);
    import pps_pkg::*;

    t_entry r_mem [MAX_TASKS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pps_ctrl.sv -----
// ----------------------------------------------------------------------------
// pps_ctrl
// Load/tick sequencer: scans the task table one entry per cycle, keeps the
// best ready task, then writes back its remaining time and reports.
// ----------------------------------------------------------------------------
module pps_ctrl #(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    parameter int CNT_W     = $clog2(MAX_TASKS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       i_cmd,
    input  logic [pps_pkg::TIME_W-1:0] i_arrival_time,
    input  logic [pps_pkg::TIME_W-1:0] i_burst_time,
    input  logic [pps_pkg::PRI_W-1:0]  i_priority_req,
    output logic                       busy,
    output logic                       o_mem_we,
    output logic [IDX_W-1:0]           o_mem_waddr,
    output pps_pkg::t_entry            o_mem_wdata,
    output logic                       o_mem_re,
    output logic [IDX_W-1:0]           o_mem_raddr,
    input  pps_pkg::t_entry            i_mem_rdata,
    output logic                       o_valid,
    output logic                       o_busy_res,
    output logic [pps_pkg::ID_W-1:0]   o_task_id,
    output logic                       o_new_segment,
    output logic                       o_finished,
    output logic [pps_pkg::TIME_W-1:0] o_finish_time,
    output logic [pps_pkg::TIME_W-1:0] o_turnaround,
    output logic [pps_pkg::TIME_W-1:0] o_waiting
);
    import pps_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    localparam logic [CNT_W-1:0] IDLE_PICK = CNT_W'(MAX_TASKS);

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_prev;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;

    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [TIME_W-1:0] r_best_arr;
    logic [TIME_W-1:0] r_best_bur;
    logic [TIME_W-1:0] r_best_rem;
    logic [PRI_W-1:0]  r_best_pri;

    logic              r_valid;
    logic              r_busy_res;
    logic [ID_W-1:0]   r_task_id;
    logic              r_new_seg;
    logic              r_fin;
    logic [TIME_W-1:0] r_fin_time;
    logic [TIME_W-1:0] r_turn;
    logic [TIME_W-1:0] r_wait;

    logic              accept;
    logic              issue;
    logic              cand_ready;
    logic              cand_better;
    logic [TIME_W-1:0] n_time;
    logic [TIME_W-1:0] rem_dec;
    logic              fin;
    logic [TIME_W-1:0] turn;
    logic [TIME_W-1:0] wait_val;
    logic [CNT_W-1:0]  pick;

    assign accept = start && (r_state == S_IDLE);
    assign issue  = (r_state == S_SCAN) && (r_rd_idx != r_count);

    assign cand_ready  = !i_mem_rdata.done && (i_mem_rdata.arrival <= r_time);
    assign cand_better = !r_found
                      || (i_mem_rdata.priority_val < r_best_pri)
                      || ((i_mem_rdata.priority_val == r_best_pri)
                          && (i_mem_rdata.arrival < r_best_arr));

    assign n_time   = (r_time != TIME_MAX) ? r_time + 1'b1 : r_time;
    assign rem_dec  = r_best_rem - 1'b1;
    assign fin      = r_found && (rem_dec == '0);
    assign turn     = n_time - r_best_arr;
    assign wait_val = (turn >= r_best_bur) ? turn - r_best_bur : '0;
    assign pick     = r_found ? CNT_W'(r_best_idx) : IDLE_PICK;

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_best_idx;
        o_mem_wdata = '{arrival: r_best_arr, burst: r_best_bur, remaining: rem_dec,
                        priority_val: r_best_pri, done: fin};
        if (accept && (i_cmd == CMD_LOAD) && (r_count != CNT_W'(MAX_TASKS))) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_count[IDX_W-1:0];
            o_mem_wdata = '{arrival: i_arrival_time, burst: i_burst_time,
                            remaining: i_burst_time, priority_val: i_priority_req,
                            done: (i_burst_time == '0)};
        end else if ((r_state == S_UPD) && r_found) begin
            o_mem_we = 1'b1;
        end
    end

    assign o_mem_re    = issue;
    assign o_mem_raddr = r_rd_idx[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_time    <= '0;
            r_prev    <= IDLE_PICK;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_cmd == CMD_TICK) begin
                            r_state   <= S_SCAN;
                            r_rd_idx  <= '0;
                            r_cmp_vld <= 1'b0;
                            r_found   <= 1'b0;
                        end else if (r_count != CNT_W'(MAX_TASKS)) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= issue;
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_cmp_vld && cand_ready && cand_better) begin
                        r_found <= 1'b1;
                    end
                    if (!issue) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_time  <= n_time;
                    r_prev  <= pick;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
        end
        if ((r_state == S_SCAN) && r_cmp_vld && cand_ready && cand_better) begin
            r_best_idx <= r_cmp_idx;
            r_best_arr <= i_mem_rdata.arrival;
            r_best_bur <= i_mem_rdata.burst;
            r_best_rem <= i_mem_rdata.remaining;
            r_best_pri <= i_mem_rdata.priority_val;
        end
        if (r_state == S_UPD) begin
            r_busy_res <= r_found;
            r_task_id  <= r_found ? ID_W'(r_best_idx) : '0;
            r_new_seg  <= (pick != r_prev);
            r_fin      <= fin;
            r_fin_time <= n_time;
            r_turn     <= fin ? turn : '0;
            r_wait     <= fin ? wait_val : '0;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_busy_res    = r_busy_res;
    assign o_task_id     = r_task_id;
    assign o_new_segment = r_new_seg;
    assign o_finished    = r_fin;
    assign o_finish_time = r_fin_time;
    assign o_turnaround  = r_turn;
    assign o_waiting     = r_wait;

endmodule

// ----- tb/priority_preemptive_scheduler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_preemptive_scheduler_tb
// Checks the scheduler against a cycle-free predictor of its task table.
// A table of directed items runs first: idle ticks, late first arrival,
// zero burst, preemption and both tie breaks. Random items follow at low
// time, then the table is filled past full while random ticks keep running.
// ----------------------------------------------------------------------------
module priority_preemptive_scheduler_tb;

    import pps_pkg::*;

    localparam int          IDLE_SEL      = MAX_TASKS_DEF;
    localparam int          LOW_TIME_TASKS = 12;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT   = 200_000;

    typedef struct packed {
        logic              busy_res;
        logic [ID_W-1:0]   task_id;
        logic              new_segment;
        logic              finished;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_tick_result;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [PRI_W-1:0]  prio;
        logic              typed;
        t_tick_result      want;
    } t_stim_row;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              start          = 1'b0;
    logic              i_cmd          = CMD_TICK;
    logic [TIME_W-1:0] i_arrival_time = '0;
    logic [TIME_W-1:0] i_burst_time   = '0;
    logic [PRI_W-1:0]  i_priority_req = '0;
    logic              busy;
    logic              o_valid;
    logic              o_busy_res;
    logic [ID_W-1:0]   o_task_id;
    logic              o_new_segment;
    logic              o_finished;
    logic [TIME_W-1:0] o_finish_time;
    logic [TIME_W-1:0] o_turnaround;
    logic [TIME_W-1:0] o_waiting;

    priority_preemptive_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .i_arrival_time (i_arrival_time),
        .i_burst_time   (i_burst_time),
        .i_priority_req (i_priority_req),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_busy_res     (o_busy_res),
        .o_task_id      (o_task_id),
        .o_new_segment  (o_new_segment),
        .o_finished     (o_finished),
        .o_finish_time  (o_finish_time),
        .o_turnaround   (o_turnaround),
        .o_waiting      (o_waiting)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scheduler mirror
    logic [TIME_W-1:0] task_arrival [MAX_TASKS_DEF];
    logic [TIME_W-1:0] task_burst   [MAX_TASKS_DEF];
    logic [TIME_W-1:0] task_left    [MAX_TASKS_DEF];
    logic [PRI_W-1:0]  task_prio    [MAX_TASKS_DEF];
    logic              task_done    [MAX_TASKS_DEF];
    int                tasks_loaded = 0;
    logic [TIME_W-1:0] now_time     = '0;
    int                last_pick    = IDLE_SEL;

    t_tick_result      pending_ticks [$];
    t_stim_row         stim_rows [$];
    t_tick_result      got_due;
    int unsigned       errors       = 0;
    int unsigned       cycle_count  = 0;

    function automatic t_tick_result result_of(input logic busy_r, input int id,
                                               input logic seg, input logic fin,
                                               input int ft, input int ta, input int wt);
        t_tick_result res;
        res.busy_res    = busy_r;
        res.task_id     = id[ID_W-1:0];
        res.new_segment = seg;
        res.finished    = fin;
        res.finish_time = ft[TIME_W-1:0];
        res.turnaround  = ta[TIME_W-1:0];
        res.waiting     = wt[TIME_W-1:0];
        return res;
    endfunction

    task automatic add_row(input logic cmd, input int arr, input int bur, input int prio,
                           input logic typed, input t_tick_result want);
        t_stim_row row;
        row.cmd     = cmd;
        row.arrival = arr[TIME_W-1:0];
        row.burst   = bur[TIME_W-1:0];
        row.prio    = prio[PRI_W-1:0];
        row.typed   = typed;
        row.want    = want;
        stim_rows.push_back(row);
    endtask

    task automatic record_load(input t_stim_row row);
        if (tasks_loaded < MAX_TASKS_DEF) begin
            task_arrival[tasks_loaded] = row.arrival;
            task_burst[tasks_loaded]   = row.burst;
            task_left[tasks_loaded]    = row.burst;
            task_prio[tasks_loaded]    = row.prio;
            task_done[tasks_loaded]    = (row.burst == '0);
            tasks_loaded++;
        end
    endtask

    // best ready task: lowest prio, then earliest arrival, then lowest index
    function automatic t_tick_result schedule_tick();
        t_tick_result      res;
        int                pick;
        bit                found;
        logic [TIME_W-1:0] turn;
        res   = '0;
        pick  = IDLE_SEL;
        found = 1'b0;
        for (int k = 0; k < tasks_loaded; k++) begin
            if (!task_done[k] && task_arrival[k] <= now_time) begin
                if (!found || task_prio[k] < task_prio[pick] ||
                    (task_prio[k] == task_prio[pick] &&
                     task_arrival[k] < task_arrival[pick])) begin
                    pick  = k;
                    found = 1'b1;
                end
            end
        end
        if (now_time != TIME_MAX) now_time++;
        if (found) begin
            res.busy_res    = 1'b1;
            res.task_id     = pick[ID_W-1:0];
            task_left[pick] = task_left[pick] - 1'b1;
            if (task_left[pick] == '0) begin
                task_done[pick] = 1'b1;
                res.finished    = 1'b1;
                turn            = now_time - task_arrival[pick];
                res.turnaround  = turn;
                res.waiting     = (turn >= task_burst[pick]) ? turn - task_burst[pick] : '0;
            end
        end
        res.new_segment = (pick != last_pick);
        res.finish_time = now_time;
        last_pick       = pick;
        return res;
    endfunction

    task automatic issue(input t_stim_row row, input bit gaps);
        t_tick_result predicted;
        if (gaps && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= row.cmd;
        i_arrival_time <= row.arrival;
        i_burst_time   <= row.burst;
        i_priority_req <= row.prio;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (row.cmd == CMD_LOAD) begin
            record_load(row);
        end else begin
            predicted = schedule_tick();
            pending_ticks.push_back(row.typed ? row.want : predicted);
        end
    endtask

    task automatic compare_field(input string name, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_ticks.size() == 0) begin
                $error("result with no tick item outstanding");
                errors++;
            end else begin
                got_due = pending_ticks.pop_front();
                compare_field("busy_res",    got_due.busy_res,    o_busy_res);
                compare_field("task_id",     got_due.task_id,     o_task_id);
                compare_field("new_segment", got_due.new_segment, o_new_segment);
                compare_field("finished",    got_due.finished,    o_finished);
                compare_field("finish_time", got_due.finish_time, o_finish_time);
                compare_field("turnaround",  got_due.turnaround,  o_turnaround);
                compare_field("waiting",     got_due.waiting,     o_waiting);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        t_tick_result none;
        none = '0;

        add_row(CMD_TICK, 0, 0, 0, 1'b1, result_of(1'b0, 0, 1'b0, 1'b0, 1, 0, 0));
        add_row(CMD_TICK, 0, 0, 0, 1'b1, result_of(1'b0, 0, 1'b0, 1'b0, 2, 0, 0));
        add_row(CMD_LOAD, 4, 2, 5, 1'b0, none);
        add_row(CMD_TICK, 0, 0, 0, 1'b1, result_of(1'b0, 0, 1'b0, 1'b0, 3, 0, 0));
        add_row(CMD_TICK, 0, 0, 0, 1'b1, result_of(1'b0, 0, 1'b0, 1'b0, 4, 0, 0));
        add_row(CMD_TICK, 0, 0, 0, 1'b1, result_of(1'b1, 0, 1'b1, 1'b0, 5, 0, 0));
        add_row(CMD_LOAD, 0, 0, 0, 1'b0, none);         // zero burst, never runs
        add_row(CMD_LOAD, 0, 3, 0, 1'b0, none);         // preempts task 0
        add_row(CMD_TICK, 0, 0, 0, 1'b0, none);
        add_row(CMD_LOAD, 3, 1, 0, 1'b0, none);         // same prio, later arrival
        repeat (5) add_row(CMD_TICK, 0, 0, 0, 1'b0, none);
        add_row(CMD_LOAD, 65535, 65535, 255, 1'b0, none);
        add_row(CMD_LOAD, 11, 2, 255, 1'b0, none);
        add_row(CMD_LOAD, 10, 1, 255, 1'b0, none);      // earlier arrival wins tie
        repeat (4) add_row(CMD_TICK, 0, 0, 0, 1'b0, none);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[n]) issue(stim_rows[n], 1'b1);

        // low time: sparse loads with near arrivals, small prio range for ties
        for (int n = 0; n < 300; n++) begin
            row = '0;
            if (tasks_loaded < LOW_TIME_TASKS && $urandom_range(0, 99) < 5) begin
                row.cmd     = CMD_LOAD;
                row.arrival = TIME_W'(now_time + $urandom_range(0, 40));
                row.burst   = ($urandom_range(0, 9) == 0) ? '0
                                                          : TIME_W'($urandom_range(1, 60));
                row.prio    = ($urandom_range(0, 3) == 0) ? PRI_W'($urandom_range(0, 255))
                                                          : PRI_W'($urandom_range(0, 3));
            end else begin
                row.cmd     = CMD_TICK;
                row.arrival = TIME_W'($urandom_range(0, 65535));
                row.burst   = TIME_W'($urandom_range(0, 65535));
                row.prio    = PRI_W'($urandom_range(0, 255));
            end
            issue(row, !(n >= 100 && n < 200));
        end

        // fill the table, then loads are ignored
        for (int n = 0; n < 300; n++) begin
            row = '0;
            if ($urandom_range(0, 99) < 10) begin
                row.cmd = CMD_LOAD;
                if (tasks_loaded < MAX_TASKS_DEF) begin
                    row.arrival = $urandom_range(0, 1) ? TIME_W'(now_time + $urandom_range(0, 40))
                                                       : TIME_W'($urandom_range(0, 65535));
                    row.burst   = ($urandom_range(0, 9) == 0) ? '0
                                                              : TIME_W'($urandom_range(1, 60));
                    row.prio    = ($urandom_range(0, 3) == 0) ? PRI_W'($urandom_range(0, 255))
                                                              : PRI_W'($urandom_range(0, 3));
                end else begin
                    row.arrival = TIME_W'($urandom_range(0, 65535));
                    row.burst   = TIME_W'($urandom_range(0, 65535));
                    row.prio    = PRI_W'($urandom_range(0, 255));
                end
            end else begin
                row.cmd     = CMD_TICK;
                row.arrival = TIME_W'($urandom_range(0, 65535));
                row.burst   = TIME_W'($urandom_range(0, 65535));
                row.prio    = PRI_W'($urandom_range(0, 255));
            end
            issue(row, 1'b1);
        end
        start <= 1'b0;

        while (pending_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_ticks.size() != 0) begin
            $error("%0d tick results never arrived", pending_ticks.size());
            errors++;
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
